// File: rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned PrioW    = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OccW     = 5;

  // Operation codes on the func field.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  // One stored entry.
  typedef struct packed {
    logic        [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } entry_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t entry;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/spq_cell.sv
// One storage cell of the sorted priority queue chain.
`default_nettype none

module spq_cell (
  input  wire logic            clk_i,
  input  wire spq_pkg::cmd_t   cmd_i,
  input  wire logic            occupied_i,
  input  wire logic            left_ge_i,
  input  wire spq_pkg::entry_t left_entry_i,
  input  wire spq_pkg::entry_t right_entry_i,
  output logic                 ge_o,
  output spq_pkg::entry_t      entry_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // True when this entry stays ahead of the incoming one.
  assign ge_o = occupied_i && ($signed(entry_q.prio) >= $signed(cmd_i.entry.prio));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.enq && !ge_o) begin
      // The first cell not ahead of the new entry takes it; the rest shift down.
      entry_d = left_ge_i ? cmd_i.entry : left_entry_i;
    end else if (cmd_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue built as a chain of shift cells.
`default_nettype none

// Bounded priority queue, highest priority at the front, arrival order among
// equal priorities. Each input item carries func (enqueue or dequeue), a data
// word and a signed priority; each input item yields exactly one result item
// with a status, the removed entry (zero unless a dequeue succeeded) and the
// occupancy after the operation.
// Both channels use valid and stall; an item moves on a rising edge with valid
// high and stall low. The result appears in the output register in the cycle
// after its input item is accepted. One item is taken per cycle unless stalled:
// every cell compares its priority with the new one in parallel and either holds,
// loads the new entry, or takes its neighbor's entry in that same cycle.
// When the receiver stalls, the held result stays put and in_stall_o rises,
// so no further item is taken until the result is gone. Taking the result
// and a new item in the same cycle is allowed.
// Reset empties the queue (count to zero) and clears the output valid; the
// cell contents are not cleared, since nothing beyond the count is ever read.
// Occupancy reports the count in five bits.

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::Capacity
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           func_i,
  input  wire logic signed [spq_pkg::ValueW-1:0] item_value_i,
  input  wire logic signed [spq_pkg::PrioW-1:0]  item_priority_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [spq_pkg::StatusW-1:0]         status_o,
  output logic signed [spq_pkg::ValueW-1:0]   removed_value_o,
  output logic signed [spq_pkg::PrioW-1:0]    removed_priority_o,
  output logic [spq_pkg::OccW-1:0]            occupancy_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            accept;
  logic [CntW-1:0] count_q, count_d;
  logic            full, empty;
  spq_pkg::cmd_t   cmd;

  logic [CAPACITY-1:0] ge;
  spq_pkg::entry_t     cell_entry [CAPACITY];

  logic                          out_valid_q;
  logic [spq_pkg::StatusW-1:0]   status_q, status_d;
  logic [spq_pkg::ValueW-1:0]    rval_q, rval_d;
  logic [spq_pkg::PrioW-1:0]     rprio_q, rprio_d;
  logic [spq_pkg::OccW-1:0]      occ_q, occ_d;
  logic [CntW+spq_pkg::OccW-1:0] count_wide;

  // A new item is taken whenever the output register is free or drains now.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q >= CntW'(CAPACITY));
  assign empty = (count_q == '0);

  assign cmd.enq         = accept && (func_i == spq_pkg::FUNC_ENQ) && !full;
  assign cmd.deq         = accept && (func_i == spq_pkg::FUNC_DEQ) && !empty;
  assign cmd.entry.value = item_value_i;
  assign cmd.entry.prio  = item_priority_i;

  // The chain: cell 0 is the front of the queue.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            occupied;
    logic            left_ge;
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;

    assign occupied = (count_q > CntW'(i));

    if (i == 0) begin : g_front
      assign left_ge    = 1'b1;
      assign left_entry = cmd.entry;
    end else begin : g_mid
      assign left_ge    = ge[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (occupied),
      .left_ge_i     (left_ge),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .ge_o          (ge[i]),
      .entry_o       (cell_entry[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::ST_OK;
    rval_d   = '0;
    rprio_d  = '0;
    unique case (func_i)
      spq_pkg::FUNC_ENQ: begin
        if (full) begin
          status_d = spq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      spq_pkg::FUNC_DEQ: begin
        if (empty) begin
          status_d = spq_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - CntW'(1);
          rval_d  = cell_entry[0].value;
          rprio_d = cell_entry[0].prio;
        end
      end
      default: begin
        status_d = spq_pkg::ST_OK;
      end
    endcase
  end

  // Occupancy is the low five bits of the count, zero-extended when narrower.
  assign count_wide = {{spq_pkg::OccW{1'b0}}, count_d};
  assign occ_d      = count_wide[spq_pkg::OccW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rval_q   <= rval_d;
      rprio_q  <= rprio_d;
      occ_q    <= occ_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign removed_value_o    = rval_q;
  assign removed_priority_o = rprio_q;
  assign occupancy_o        = occ_q;

endmodule

`default_nettype wire

// File: sim/sorted_priority_queue_test.sv
// Self-checking testbench for the sorted priority queue: ordering, ties, full and empty.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned RANDOM_OPS   = 750;

  // Directed fill: both priority extremes, ties at the top, bottom and middle.
  localparam logic signed [ValueW-1:0] FILL_VALUE [16] = '{
    32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff,
    32'h00000011, 32'h00000022, 32'h00000033, 32'h00000044,
    32'h00000055, 32'h00000066, 32'h00000077, 32'h00000088,
    32'h00000099, 32'ha5a5a5a5, 32'h5a5a5a5a, 32'h12345678};
  localparam logic signed [PrioW-1:0] FILL_PRIO [16] = '{
    16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
    16'sd5,    16'sd5,    16'sd5,    16'sd1,
    16'sh8000, 16'sh7fff, 16'sd100,  -16'sd100,
    16'sd5,    16'sh0000, 16'sd2,    16'sd3};

  typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} op_phase_e;

  typedef struct {
    logic [StatusW-1:0]       status;
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
    logic [OccW-1:0]          occ;
  } queue_result_t;

  // Shadow copy of the queue contents; predicts one result per accepted item.
  class queue_shadow;
    logic signed [ValueW-1:0] held_values [Capacity];
    logic signed [PrioW-1:0]  held_prios [Capacity];
    int unsigned              held_count;
    queue_result_t            pending_results [$];
    int unsigned              mismatch_count;

    function new();
      held_count     = 0;
      mismatch_count = 0;
    endfunction

    function void apply_op(logic op, logic signed [ValueW-1:0] value,
                           logic signed [PrioW-1:0] prio);
      queue_result_t r;
      int unsigned   slot;
      int unsigned   k;
      r.status = ST_OK;
      r.value  = '0;
      r.prio   = '0;
      if (op == FUNC_ENQ) begin
        if (held_count >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          // New entry goes behind every entry of higher or equal priority.
          slot = 0;
          while (slot < held_count && held_prios[slot] >= prio) slot++;
          for (k = held_count; k > slot; k--) begin
            held_values[k] = held_values[k-1];
            held_prios[k]  = held_prios[k-1];
          end
          held_values[slot] = value;
          held_prios[slot]  = prio;
          held_count++;
        end
      end else begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = held_values[0];
          r.prio  = held_prios[0];
          for (k = 1; k < held_count; k++) begin
            held_values[k-1] = held_values[k];
            held_prios[k-1]  = held_prios[k];
          end
          held_count--;
        end
      end
      r.occ = OccW'(held_count);
      pending_results.push_back(r);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void compare_field(string name, logic [ValueW-1:0] expected,
                                logic [ValueW-1:0] actual);
      if (actual !== expected) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
        mismatch_count++;
      end
    endfunction

    function void match_result(logic [StatusW-1:0] status, logic signed [ValueW-1:0] value,
                               logic signed [PrioW-1:0] prio, logic [OccW-1:0] occ);
      queue_result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, status %h value %h priority %h occ %0d",
                 $time, status, value, prio, occ);
        mismatch_count++;
        return;
      end
      r = pending_results.pop_front();
      compare_field("status", ValueW'(r.status), ValueW'(status));
      compare_field("removed_value", r.value, value);
      compare_field("removed_priority", ValueW'(r.prio), ValueW'(prio));
      compare_field("occupancy", ValueW'(r.occ), ValueW'(occ));
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       func_i = FUNC_ENQ;
  logic signed [ValueW-1:0]   item_value_i = '0;
  logic signed [PrioW-1:0]    item_priority_i = '0;
  logic                       out_stall_i = 1'b0;
  logic                       in_stall_o;
  logic                       out_valid_o;
  logic [StatusW-1:0]         status_o;
  logic signed [ValueW-1:0]   removed_value_o;
  logic signed [PrioW-1:0]    removed_priority_o;
  logic [OccW-1:0]            occupancy_o;

  queue_shadow shadow = new();
  int unsigned cycle_count = 0;

  sorted_priority_queue dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .item_value_i      (item_value_i),
    .item_priority_i   (item_priority_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .removed_value_o   (removed_value_o),
    .removed_priority_o(removed_priority_o),
    .occupancy_o       (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Both monitors see the values settled before the edge, since every
  // register and every testbench input changes in the nonblocking region.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      shadow.apply_op(func_i, item_value_i, item_priority_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      shadow.match_result(status_o, removed_value_o, removed_priority_o, occupancy_o);
    end
  end

  // Receiver stall pattern: modes of random length, from never stalling
  // through a periodic stall to stalling most of the time.
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 99) < 30);
      end
      2: begin
        out_stall_i <= (stall_tick % 4 == 0);
      end
      default: begin
        out_stall_i <= ($urandom_range(0, 99) < 75);
      end
    endcase
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Presents one item and returns at the edge where it is taken.
  task automatic send_item(input logic op, input logic signed [ValueW-1:0] value,
                           input logic signed [PrioW-1:0] prio);
    in_valid_i      <= 1'b1;
    func_i          <= op;
    item_value_i    <= value;
    item_priority_i <= prio;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (shadow.pending() != 0);
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    int i;
    // Dequeue from empty, with non-zero fields that must be ignored.
    send_item(FUNC_DEQ, 32'hdeadbeef, 16'sh7fff);
    for (i = 0; i < 16; i++) send_item(FUNC_ENQ, FILL_VALUE[i], FILL_PRIO[i]);
    // Queue is full now; this one is rejected.
    send_item(FUNC_ENQ, 32'h0badf00d, 16'sh7fff);
    for (i = 0; i < 6; i++) send_item(FUNC_DEQ, '0, '0);
  endtask

  function automatic logic signed [PrioW-1:0] pick_priority();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    // Narrow range most of the time so that ties are common.
    if (sel < 6) return PrioW'($urandom_range(0, 6)) - 16'sd3;
    if (sel == 6) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    return PrioW'($urandom);
  endfunction

  task automatic run_random();
    op_phase_e   phase;
    int unsigned phase_left;
    int unsigned burst_left;
    int unsigned enq_pct;
    bit          no_gaps;
    int unsigned n;
    logic        op;
    phase      = PHASE_MIXED;
    phase_left = 0;
    burst_left = 0;
    no_gaps    = 1'b0;
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (phase_left == 0) begin
        phase      = op_phase_e'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 60);
        no_gaps    = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      if (n % 150 == 149) wait_for_drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if (!no_gaps) idle_sender($urandom_range(0, 8));
      end
      burst_left--;
      case (phase)
        PHASE_FILL:  enq_pct = 80;
        PHASE_DRAIN: enq_pct = 20;
        default:     enq_pct = 50;
      endcase
      op = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
      send_item(op, ValueW'($urandom), pick_priority());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wait_for_drain();
    run_random();
    wait_for_drain();
    repeat (5) @(posedge clk_i);
    if (shadow.mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
